@@ src/cet_pkg.sv @@
// Shared types, constants and the quarter-cosine table builder of the cosine edge taper.
package cet_pkg;

   localparam int MAX_TIME_DEF  = 4096;
   localparam int MAX_SPACE_DEF = 1024;
   localparam int COS_DEPTH_DEF = 256;

   // Weights are Q0.16 with 65536 meaning one, so they need 17 bits.
   localparam int W_W    = 17;
   localparam int W_ONE  = 65536;
   localparam int SAMPLE_W = 32;
   localparam int PROD_W = 49;

   // Position, size and ramp arithmetic runs at this width; sizes stay below 8192.
   localparam int CW    = 14;
   localparam int LEN_W = 10;
   localparam int TS_W  = 13;
   localparam int SS_W  = 11;
   localparam int AXES  = 5;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_TIME_SIZE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_RAMP_LEN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_SIZES     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPACE_RAMP_LENS = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_ENABLES    = 3'd4;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_ROM,
      ST_WEIGHT,
      ST_SMUL,
      ST_EMIT
   } step_type;

   typedef enum logic [2:0] {
      C_NONE,
      C_ALWAYS,
      C_NO_INPUT,
      C_NO_RAMP,
      C_DIV_BUSY,
      C_MORE_AXES,
      C_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     setup;
      logic     div_step;
      logic     rom_rd;
      logic     weight;
      logic     smul;
      logic     emit;
      cond_type hold_cond;
      cond_type jump_cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic no_input;
      logic no_ramp;
      logic div_busy;
      logic more_axes;
      logic out_busy;
   } status_type;

   // Cosine of a Q30 angle by a thirteen-term Taylor series, each term truncated,
   // rounded to 16 fraction bits and clamped to the range zero to one.
   function automatic logic [W_W-1:0] cos_from_x(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        r;
      logic signed [63:0] sum;
      x2   = (x * x) >> 30;
      term = ONE_Q30;
      sum  = $signed(ONE_Q30);
      for (int n = 1; n <= 12; n++) begin
         term = (term * x2) >> 30;
         term = term / 64'((2 * n - 1) * (2 * n));
         if (n[0]) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum <= 0) begin
         r = 64'd0;
      end else begin
         r = ($unsigned(sum) + 64'd8192) >> 14;
      end
      if (r > 64'(W_ONE)) begin
         r = 64'(W_ONE);
      end
      return r[W_W-1:0];
   endfunction

endpackage

@@ src/cet_cos_rom.sv @@
// Quarter-cosine table, built at elaboration, with a registered read port.
module cet_cos_rom #(
   parameter int TAB_DEPTH = cet_pkg::COS_DEPTH_DEF,
   localparam int AW = $clog2(TAB_DEPTH + 1)
) (
   input  logic                    clock,
   input  logic                    rd,
   input  logic [AW-1:0]           addr,
   output logic [cet_pkg::W_W-1:0] data
);

   logic [cet_pkg::W_W-1:0] tab [TAB_DEPTH+1];
   logic [cet_pkg::W_W-1:0] data_ff;
   logic [AW-1:0]           addr_c;

   for (genvar g = 0; g <= TAB_DEPTH; g++) begin : g_tab
      localparam logic [63:0] X =
         (64'(g) * cet_pkg::HALF_PI_Q30 + 64'(TAB_DEPTH / 2)) / 64'(TAB_DEPTH);
      assign tab[g] = cet_pkg::cos_from_x(X);
   end

   // Codes above the table depth never arrive; they read the last entry.
   assign addr_c = (addr > AW'(TAB_DEPTH)) ? AW'(TAB_DEPTH) : addr;

   always_ff @(posedge clock) begin
      if (rd) begin
         data_ff <= tab[addr_c];
      end
   end

   assign data = data_ff;

endmodule

@@ src/cet_div.sv @@
// Restoring divider that forms the rounded table index, one quotient bit a cycle while step is high.
module cet_div #(
   parameter int TAB_DEPTH = cet_pkg::COS_DEPTH_DEF,
   localparam int QW = $clog2(TAB_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic                      step,
   input  logic [cet_pkg::LEN_W-1:0] m,
   input  logic [cet_pkg::LEN_W-1:0] len,
   output logic [QW-1:0]             quot,
   output logic                      last
);

   localparam int NUM_W = cet_pkg::LEN_W + $clog2(2 * TAB_DEPTH) + 1;
   localparam int CNT_W = $clog2(QW);
   localparam int R_W   = cet_pkg::LEN_W + 1;

   logic [NUM_W-1:0] num;
   logic [R_W-1:0]   rem_ff, rem_in;
   logic [R_W-1:0]   den_ff;
   logic [QW-1:0]    low_ff, low_in;
   logic [QW-1:0]    q_ff, q_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [R_W:0]     trial;
   logic             ge;

   // Numerator m*2*depth + len over divisor 2*len rounds m*depth/len, ties up.
   // The quotient never exceeds the depth, so the top part starts below the divisor.
   assign num   = NUM_W'(m) * NUM_W'(2 * TAB_DEPTH) + NUM_W'(len);
   assign trial = {rem_ff, low_ff[QW-1]};
   assign ge    = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in = ge ? R_W'(trial - {1'b0, den_ff}) : trial[R_W-1:0];
      low_in = {low_ff[QW-2:0], 1'b0};
      q_in   = {q_ff[QW-2:0], ge};
      cnt_in = cnt_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= '0;
      end else if (step) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= R_W'(num >> QW);
         low_ff <= num[QW-1:0];
         den_ff <= {len, 1'b0};
      end else if (step) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
         q_ff   <= q_in;
      end
   end

   assign quot = q_ff;
   assign last = cnt_ff == CNT_W'(QW - 1);

endmodule

@@ src/cet_seq.sv @@
// Microcode sequencer: step counter, control-word table and conditional jumps.
module cet_seq (
   input  logic                clock,
   input  logic                reset,
   input  cet_pkg::status_type status,
   output cet_pkg::ctrl_type   ctrl
);

   cet_pkg::step_type step_ff, step_in;
   logic              hold;
   logic              jump;

   function automatic cet_pkg::ctrl_type ucode(input cet_pkg::step_type s);
      cet_pkg::ctrl_type c;
      c = '0;
      case (s)
         cet_pkg::ST_IDLE: begin
            c.accept    = 1'b1;
            c.hold_cond = cet_pkg::C_NO_INPUT;
            c.jump_cond = cet_pkg::C_ALWAYS;
            c.target    = cet_pkg::ST_SETUP;
         end
         cet_pkg::ST_SETUP: begin
            c.setup     = 1'b1;
            c.jump_cond = cet_pkg::C_NO_RAMP;
            c.target    = cet_pkg::ST_WEIGHT;
         end
         cet_pkg::ST_DIV: begin
            c.div_step  = 1'b1;
            c.hold_cond = cet_pkg::C_DIV_BUSY;
         end
         cet_pkg::ST_ROM: begin
            c.rom_rd = 1'b1;
         end
         cet_pkg::ST_WEIGHT: begin
            c.weight    = 1'b1;
            c.jump_cond = cet_pkg::C_MORE_AXES;
            c.target    = cet_pkg::ST_SETUP;
         end
         cet_pkg::ST_SMUL: begin
            c.smul = 1'b1;
         end
         cet_pkg::ST_EMIT: begin
            c.emit      = 1'b1;
            c.hold_cond = cet_pkg::C_OUT_BUSY;
            c.jump_cond = cet_pkg::C_ALWAYS;
            c.target    = cet_pkg::ST_IDLE;
         end
         default: begin
            c.jump_cond = cet_pkg::C_ALWAYS;
            c.target    = cet_pkg::ST_IDLE;
         end
      endcase
      return c;
   endfunction

   function automatic logic cond_true(input cet_pkg::cond_type cd,
                                      input cet_pkg::status_type st);
      logic t;
      case (cd)
         cet_pkg::C_ALWAYS:    t = 1'b1;
         cet_pkg::C_NO_INPUT:  t = st.no_input;
         cet_pkg::C_NO_RAMP:   t = st.no_ramp;
         cet_pkg::C_DIV_BUSY:  t = st.div_busy;
         cet_pkg::C_MORE_AXES: t = st.more_axes;
         cet_pkg::C_OUT_BUSY:  t = st.out_busy;
         default:              t = 1'b0;
      endcase
      return t;
   endfunction

   always_comb begin
      ctrl = ucode(step_ff);
      hold = cond_true(ctrl.hold_cond, status);
      jump = cond_true(ctrl.jump_cond, status);
      if (hold) begin
         step_in = step_ff;
      end else if (jump) begin
         step_in = ctrl.target;
      end else begin
         step_in = cet_pkg::step_type'(step_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= cet_pkg::ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ src/cosine_edge_taper_5d_core.sv @@
// Top level of the five-axis cosine edge taper: registers, counters and datapath.
//
//   channel  direction  handshake            payload
//   req      in         req_tvalid/tready    tdata[31:0] sample
//   rsp      out        rsp_tvalid/tready    tdata[31:0] tapered_sample, tlast patch_end
//   csr      in         csr_wen              csr_index, csr_wdata
//
// A transaction takes an accept step, then for each of the five axes a setup and a weight
// step when the sample lies outside every enabled ramp of that axis, or inside one a setup
// step, QW divider steps, a table read and a weight step; QW = clog2(COS_TABLE_DEPTH+1)
// is the number of steps of the bit-serial index divider. A product step and an output step
// then form the product and load the output register. Reset is synchronous; there is no
// clearing pass. The result sits in an output register, so the next sample is accepted while
// it waits; the sequencer stalls only when a finished result finds the previous one untaken.
module cosine_edge_taper_5d_core #(
   parameter int MAX_TIME        = cet_pkg::MAX_TIME_DEF,
   parameter int MAX_SPACE       = cet_pkg::MAX_SPACE_DEF,
   parameter int COS_TABLE_DEPTH = cet_pkg::COS_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input stream.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cet_pkg::SAMPLE_W-1:0]  req_tdata,   // [31:0] sample
   // Result stream.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [cet_pkg::SAMPLE_W-1:0]  rsp_tdata,   // [31:0] tapered_sample
   output logic                          rsp_tlast,   // patch_end
   // Register write port.
   input  logic                          csr_wen,
   input  logic [cet_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cet_pkg::CSR_W-1:0]     csr_wdata
);

   // The time size register cannot exceed 8191 and a spatial size cannot exceed 1024,
   // so the position counters are sized by whichever bound is tighter.
   localparam int TMAX = (MAX_TIME < 8191) ? MAX_TIME : 8191;
   localparam int SMAX = (MAX_SPACE < 1024) ? MAX_SPACE : 1024;
   localparam int TP_W = $clog2(TMAX);
   localparam int SP_W = (SMAX > 1) ? $clog2(SMAX) : 1;
   localparam int QW   = $clog2(COS_TABLE_DEPTH + 1);
   localparam int CW   = cet_pkg::CW;
   localparam int W_W  = cet_pkg::W_W;
   localparam int LEN_W = cet_pkg::LEN_W;

   // Configuration registers.
   logic [cet_pkg::TS_W-1:0] time_size_ff;
   logic [LEN_W-1:0]         time_ramp_len_ff;
   logic [39:0]              space_sizes_ff;
   logic [31:0]              space_ramp_lens_ff;
   logic [9:0]               edge_enables_ff;

   // Position counters.
   logic [TP_W-1:0] tp_ff, tp_in;
   logic [SP_W-1:0] sp_ff [4];
   logic [SP_W-1:0] sp_in [4];
   logic            last_c;

   // Datapath registers.
   logic signed [cet_pkg::SAMPLE_W-1:0] sample_ff;
   logic [2:0]                          axis_ff;
   logic                                ramp_ff;
   logic                                end_ff;
   logic [W_W-1:0]                      w_ff, w_in;
   logic signed [cet_pkg::PROD_W-1:0]   p_ff;

   // Output register.
   logic                         rsp_tvalid_ff;
   logic [cet_pkg::SAMPLE_W-1:0] rsp_data_ff;
   logic                         rsp_last_ff;

   cet_pkg::ctrl_type   ctrl;
   cet_pkg::status_type status;

   // Effective axis sizes.
   logic [cet_pkg::TS_W-1:0] tn;
   logic [cet_pkg::SS_W-1:0] sn [4];
   logic [7:0]               slen [4];

   // Per-axis ramp decision.
   logic [1:0]       sidx;
   logic [CW-1:0]    k_c, n_c, kc, len14, m14;
   logic [LEN_W-1:0] len_c;
   logic [1:0]       en_c;
   logic             start_act, end_act;

   logic [QW-1:0]  quot;
   logic           div_last;
   logic [W_W-1:0] rom_q;
   logic [W_W-1:0] wt;
   logic [2*W_W-1:0] wprod;
   logic signed [cet_pkg::SAMPLE_W+W_W:0] sprod;

   // Rounding of the final product, half away from zero.
   logic                         neg;
   logic [cet_pkg::PROD_W-1:0]   mag;
   logic [cet_pkg::SAMPLE_W:0]   rnd;
   logic [cet_pkg::SAMPLE_W-1:0] result_c;

   logic out_busy;
   logic emit_go;

   cet_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   cet_div #(
      .TAB_DEPTH (COS_TABLE_DEPTH)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .load  (ctrl.setup),
      .step  (ctrl.div_step),
      .m     (m14[LEN_W-1:0]),
      .len   (len_c),
      .quot  (quot),
      .last  (div_last)
   );

   cet_cos_rom #(
      .TAB_DEPTH (COS_TABLE_DEPTH)
   ) u_rom (
      .clock (clock),
      .rd    (ctrl.rom_rd),
      .addr  (quot),
      .data  (rom_q)
   );

   // A zero time size counts as one; sizes beyond the counter range saturate.
   always_comb begin
      if (time_size_ff == '0) begin
         tn = cet_pkg::TS_W'(1);
      end else if (time_size_ff > cet_pkg::TS_W'(TMAX)) begin
         tn = cet_pkg::TS_W'(TMAX);
      end else begin
         tn = time_size_ff;
      end
      for (int a = 0; a < 4; a++) begin
         sn[a]   = {1'b0, space_sizes_ff[10*a +: 10]} + cet_pkg::SS_W'(1);
         if (sn[a] > cet_pkg::SS_W'(SMAX)) begin
            sn[a] = cet_pkg::SS_W'(SMAX);
         end
         slen[a] = space_ramp_lens_ff[8*a +: 8];
      end
   end

   // Select the axis under work and decide which ramp, if any, applies. A position at
   // or past its size is weighted as the last one. The end ramp wins over the start ramp.
   always_comb begin
      sidx = 2'(axis_ff - 3'd1);
      if (axis_ff == 3'd0) begin
         k_c   = CW'(tp_ff);
         n_c   = CW'(tn);
         len_c = time_ramp_len_ff;
      end else begin
         k_c   = CW'(sp_ff[sidx]);
         n_c   = CW'(sn[sidx]);
         len_c = LEN_W'(slen[sidx]);
      end
      en_c      = edge_enables_ff[{axis_ff, 1'b0} +: 2];
      kc        = (k_c >= n_c) ? n_c - CW'(1) : k_c;
      len14     = CW'(len_c);
      start_act = en_c[0] && (kc < len14);
      end_act   = en_c[1] && (len_c != '0) && (kc + len14 > n_c);
      m14       = end_act ? kc + len14 - n_c : kc;
   end

   // Axis weight, then the running product of weights rounded back to Q0.16.
   always_comb begin
      if (!ramp_ff) begin
         wt = W_W'(cet_pkg::W_ONE);
      end else if (end_ff) begin
         wt = rom_q;
      end else begin
         wt = W_W'(cet_pkg::W_ONE) - rom_q;
      end
      wprod = w_ff * wt;
      if (axis_ff == 3'd0) begin
         w_in = wt;
      end else begin
         w_in = W_W'((wprod + (2*W_W)'(32768)) >> 16);
      end
      sprod = sample_ff * $signed({1'b0, w_ff});
   end

   always_comb begin
      neg      = p_ff[cet_pkg::PROD_W-1];
      mag      = neg ? $unsigned(-p_ff) : $unsigned(p_ff);
      rnd      = (cet_pkg::SAMPLE_W+1)'((mag + cet_pkg::PROD_W'(32768)) >> 16);
      result_c = neg ? cet_pkg::SAMPLE_W'(-rnd) : rnd[cet_pkg::SAMPLE_W-1:0];
   end

   // Counter advance: the time axis carries into axis two, and so on up to axis five.
   // The patch ends when every axis wraps together.
   always_comb begin
      logic carry;
      carry  = (CW'(tp_ff) + CW'(1)) >= CW'(tn);
      last_c = carry;
      tp_in  = carry ? '0 : tp_ff + TP_W'(1);
      for (int a = 0; a < 4; a++) begin
         sp_in[a] = sp_ff[a];
         if (carry) begin
            if ((CW'(sp_ff[a]) + CW'(1)) >= CW'(sn[a])) begin
               sp_in[a] = '0;
            end else begin
               sp_in[a] = sp_ff[a] + SP_W'(1);
               carry    = 1'b0;
               last_c   = 1'b0;
            end
         end
      end
   end

   assign out_busy = rsp_tvalid_ff && !rsp_tready;
   assign emit_go  = ctrl.emit && !out_busy;

   always_comb begin
      status.no_input  = !req_tvalid;
      status.no_ramp   = !(start_act || end_act);
      status.div_busy  = !div_last;
      status.more_axes = axis_ff != 3'(cet_pkg::AXES - 1);
      status.out_busy  = out_busy;
   end

   // Register writes; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_size_ff       <= cet_pkg::TS_W'(4096);
         time_ramp_len_ff   <= '0;
         space_sizes_ff     <= '0;
         space_ramp_lens_ff <= '0;
         edge_enables_ff    <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            cet_pkg::CSR_TIME_SIZE:       time_size_ff       <= csr_wdata[12:0];
            cet_pkg::CSR_TIME_RAMP_LEN:   time_ramp_len_ff   <= csr_wdata[9:0];
            cet_pkg::CSR_SPACE_SIZES:     space_sizes_ff     <= csr_wdata[39:0];
            cet_pkg::CSR_SPACE_RAMP_LENS: space_ramp_lens_ff <= csr_wdata[31:0];
            cet_pkg::CSR_EDGE_ENABLES:    edge_enables_ff    <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // Position counters and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         tp_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int a = 0; a < 4; a++) begin
            sp_ff[a] <= '0;
         end
      end else begin
         if (emit_go) begin
            tp_ff         <= tp_in;
            rsp_tvalid_ff <= 1'b1;
            for (int a = 0; a < 4; a++) begin
               sp_ff[a] <= sp_in[a];
            end
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_data_ff <= result_c;
         rsp_last_ff <= last_c;
      end
   end

   // Datapath registers driven by the control word.
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff <= '0;
      end else if (ctrl.accept && req_tvalid) begin
         axis_ff <= '0;
      end else if (ctrl.weight) begin
         axis_ff <= axis_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.accept && req_tvalid) begin
         sample_ff <= $signed(req_tdata);
      end
      if (ctrl.setup) begin
         ramp_ff <= start_act || end_act;
         end_ff  <= end_act;
      end
      if (ctrl.weight) begin
         w_ff <= w_in;
      end
      if (ctrl.smul) begin
         p_ff <= sprod[cet_pkg::PROD_W-1:0];
      end
   end

   assign req_tready = ctrl.accept;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The weight product must never exceed one.
   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      $past(ctrl.weight) |-> (w_ff <= W_W'(cet_pkg::W_ONE)))
      else $error("weight product above one");

   // One sample at a time: the port closes right after a transaction.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second sample accepted while one is in work");

   // A result appears only from the output step of the program.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(ctrl.emit))
      else $error("result raised outside the output step");

   // The time counter stays inside the largest time axis.
   a_time_pos: assert property (@(posedge clock) disable iff (reset)
      CW'(tp_ff) < CW'(TMAX))
      else $error("time position out of range");

endmodule
